// File: sv/fslm_pkg.sv
// package for the fixed-string line matcher: sizes, codes, payload types and helpers
`timescale 1ns / 1ps

package fslm_pkg;

    localparam int MAX_QUERY    = 16;
    localparam int LINE_CAP     = 4096;
    localparam int OFFSET_BITS  = 40;
    localparam int FILE_BITS    = 14;
    localparam int LEN_BITS     = $clog2(LINE_CAP + 1);
    localparam int QLEN_BITS    = 5;
    localparam int FILL_BITS    = $clog2(MAX_QUERY + 1);
    localparam int QIDX_BITS    = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
    localparam int CFG_BITS     = 64;
    localparam int PADDR_BITS   = 5;
    localparam int REG_SEL_LSB  = 3;
    localparam int REG_SEL_BITS = PADDR_BITS - REG_SEL_LSB;
    localparam int QREG_BYTES   = 8;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic [REG_SEL_BITS-1:0] REG_QUERY_LENGTH = REG_SEL_BITS'(0);
    localparam logic [REG_SEL_BITS-1:0] REG_QUERY_LOW    = REG_SEL_BITS'(1);
    localparam logic [REG_SEL_BITS-1:0] REG_QUERY_HIGH   = REG_SEL_BITS'(2);

    typedef logic [OFFSET_BITS-1:0] t_offset;

    typedef struct packed {
        logic [7:0]           data_byte;
        logic [FILE_BITS-1:0] file_id;
        logic                 last_byte;
    } t_in_item;

    typedef struct packed {
        logic [FILE_BITS-1:0] match_file;
        t_offset              line_offset;
        logic [LEN_BITS-1:0]  line_length;
    } t_out_item;

    function automatic logic is_break(input logic [7:0] b);
        return (b == CH_LF) || (b == CH_CR);
    endfunction

endpackage

// File: sv/fixed_string_line_matcher_unit.sv
// fixed-string line matcher: window compare, segment tracking, record output, register port
`timescale 1ns / 1ps

// Streams file bytes one per transfer and reports, for the first query hit in each
// LF-delimited line, the CR/LF-delimited segment holding the hit start (file number,
// start offset, length saturated at 4096). One byte is taken every clock cycle unless the input stalls: the
// 16-byte window compare, the break searches and the length subtract all sit in combinational
// logic between the state registers and the output register, so a record appears in the
// cycle after the byte that completes it. The input stalls only while a record waits
// in the output register and the output side stalls. All matching state clears after
// a byte marked last. Registers sit at byte addresses 0 (query length), 8 (query
// bytes 0-7) and 16 (query bytes 8-15), 64 bits wide, and should be written between
// files.
module fixed_string_line_matcher_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fslm_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fslm_pkg::t_out_item                 o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fslm_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [fslm_pkg::CFG_BITS-1:0]       pwdata,
    output logic [fslm_pkg::CFG_BITS-1:0]       prdata,
    output logic                                pready
);
    import fslm_pkg::*;

    logic [QLEN_BITS-1:0]  r_query_length;
    logic [CFG_BITS-1:0]   r_query_low;
    logic [CFG_BITS-1:0]   r_query_high;

    logic [7:0]            r_win [MAX_QUERY];
    logic [FILL_BITS-1:0]  r_fill;
    t_offset               r_byte_pos;
    t_offset               r_seg_start;
    t_offset               r_resume;
    logic                  r_waiting;
    logic                  r_pending_valid;
    t_offset               r_pending_start;
    logic                  r_out_valid;
    t_out_item             r_out_data;

    logic [7:0]            n_win [MAX_QUERY];
    logic [FILL_BITS-1:0]  n_fill;
    t_offset               n_byte_pos;
    t_offset               n_seg_start;
    t_offset               n_resume;
    logic                  n_waiting;
    logic                  n_pending_valid;
    t_offset               n_pending_start;
    logic                  n_out_valid;
    t_out_item             n_out_data;

    logic [7:0]            qbyte [MAX_QUERY];
    logic [QLEN_BITS-1:0]  q_eff;
    logic                  in_fire;
    logic                  cfg_wr;
    logic [REG_SEL_BITS-1:0] reg_sel;

    logic                  hit;
    logic                  end_found;
    logic                  lf_in;
    logic                  flush_hit;
    logic                  try_match;
    logic                  emit;
    t_offset               pos;
    t_offset               start_m;
    t_offset               end_m;
    t_offset               res_m;
    t_offset               hit_pos;
    t_offset               resume1;
    t_offset               emit_start;
    t_offset               emit_end;
    t_offset               seg_len;
    logic                  wait1;
    logic [QIDX_BITS-1:0]  qidx;

    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign reg_sel     = paddr[PADDR_BITS-1:REG_SEL_LSB];
    assign pos         = r_byte_pos;

    always_comb begin
        unique case (reg_sel)
            REG_QUERY_LENGTH: prdata = CFG_BITS'(r_query_length);
            REG_QUERY_LOW:    prdata = r_query_low;
            REG_QUERY_HIGH:   prdata = r_query_high;
            default:          prdata = '0;
        endcase
    end

    // query bytes past the two registers read as zero
    always_comb begin
        for (int i = 0; i < MAX_QUERY; i++) begin
            if (i < QREG_BYTES) begin
                qbyte[i] = r_query_low[8*(i % QREG_BYTES) +: 8];
            end else if (i < 2 * QREG_BYTES) begin
                qbyte[i] = r_query_high[8*(i % QREG_BYTES) +: 8];
            end else begin
                qbyte[i] = 8'h00;
            end
        end
        if (int'(r_query_length) > MAX_QUERY) begin
            q_eff = QLEN_BITS'(MAX_QUERY);
        end else begin
            q_eff = r_query_length;
        end
    end

    always_comb begin
        n_win[0] = i_in_data.data_byte;
        for (int k = 1; k < MAX_QUERY; k++) begin
            n_win[k] = r_win[k-1];
        end
        n_fill = (int'(r_fill) < MAX_QUERY) ? r_fill + FILL_BITS'(1) : r_fill;

        // a break leaving the window moves the segment start
        if (is_break(r_win[MAX_QUERY-1])) begin
            n_seg_start = pos - t_offset'(MAX_QUERY - 1);
        end else begin
            n_seg_start = r_seg_start;
        end

        hit  = 1'b1;
        qidx = '0;
        for (int k = 0; k < MAX_QUERY; k++) begin
            if (k < int'(q_eff)) begin
                qidx = QIDX_BITS'(int'(q_eff) - 1 - k);
                if (n_win[k] != qbyte[qidx]) begin
                    hit = 1'b0;
                end
            end
        end

        // nearest break before the hit
        start_m = n_seg_start;
        for (int k = MAX_QUERY - 1; k >= 0; k--) begin
            if (k >= int'(q_eff) && k < int'(n_fill) && is_break(n_win[k])) begin
                start_m = pos - t_offset'(k) + t_offset'(1);
            end
        end

        // first break at or after the hit start
        end_found = 1'b0;
        end_m     = '0;
        lf_in     = 1'b0;
        res_m     = '0;
        for (int j = 0; j < MAX_QUERY; j++) begin
            if (j < int'(q_eff) && is_break(n_win[j])) begin
                end_found = 1'b1;
                end_m     = pos - t_offset'(j);
            end
            if (j + 1 < int'(q_eff) && n_win[j] == CH_LF) begin
                lf_in = 1'b1;
                res_m = pos - t_offset'(j) + t_offset'(1);
            end
        end

        flush_hit = r_pending_valid && is_break(i_in_data.data_byte);
        wait1     = r_waiting;
        resume1   = r_resume;
        if (r_waiting && i_in_data.data_byte == CH_LF) begin
            wait1   = 1'b0;
            resume1 = pos + t_offset'(1);
        end

        hit_pos   = pos - t_offset'(int'(q_eff) - 1);
        try_match = (q_eff != '0) && !flush_hit && !wait1
                    && (int'(n_fill) >= int'(q_eff)) && hit && (hit_pos >= resume1);

        n_pending_valid = r_pending_valid && !flush_hit;
        n_pending_start = r_pending_start;
        n_waiting       = wait1;
        n_resume        = resume1;
        emit            = flush_hit;
        emit_start      = r_pending_start;
        emit_end        = pos;

        if (try_match) begin
            if (end_found) begin
                emit       = 1'b1;
                emit_start = start_m;
                emit_end   = end_m;
            end else begin
                n_pending_valid = 1'b1;
                n_pending_start = start_m;
            end
            n_waiting = !lf_in;
            n_resume  = lf_in ? res_m : resume1;
        end

        n_byte_pos = pos + t_offset'(1);

        if (i_in_data.last_byte) begin
            if (n_pending_valid && !emit) begin
                emit       = 1'b1;
                emit_start = n_pending_start;
                emit_end   = pos + t_offset'(1);
            end
            for (int k = 0; k < MAX_QUERY; k++) begin
                n_win[k] = 8'h00;
            end
            n_fill          = '0;
            n_byte_pos      = '0;
            n_seg_start     = '0;
            n_resume        = '0;
            n_waiting       = 1'b0;
            n_pending_valid = 1'b0;
            n_pending_start = '0;
        end

        seg_len                = emit_end - emit_start;
        n_out_data.match_file  = i_in_data.file_id;
        n_out_data.line_offset = emit_start;
        if (seg_len > t_offset'(LINE_CAP)) begin
            n_out_data.line_length = LEN_BITS'(LINE_CAP);
        end else begin
            n_out_data.line_length = seg_len[LEN_BITS-1:0];
        end

        if (in_fire && emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_length  <= QLEN_BITS'(1);
            r_query_low     <= '0;
            r_query_high    <= '0;
            for (int k = 0; k < MAX_QUERY; k++) begin
                r_win[k] <= 8'h00;
            end
            r_fill          <= '0;
            r_byte_pos      <= '0;
            r_seg_start     <= '0;
            r_resume        <= '0;
            r_waiting       <= 1'b0;
            r_pending_valid <= 1'b0;
            r_pending_start <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (reg_sel)
                    REG_QUERY_LENGTH: r_query_length <= pwdata[QLEN_BITS-1:0];
                    REG_QUERY_LOW:    r_query_low    <= pwdata;
                    REG_QUERY_HIGH:   r_query_high   <= pwdata;
                    default: ;
                endcase
            end
            if (in_fire) begin
                r_win           <= n_win;
                r_fill          <= n_fill;
                r_byte_pos      <= n_byte_pos;
                r_seg_start     <= n_seg_start;
                r_resume        <= n_resume;
                r_waiting       <= n_waiting;
                r_pending_valid <= n_pending_valid;
                r_pending_start <= n_pending_start;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && emit) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef SYNTHESIS
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.line_length <= LEN_BITS'(LINE_CAP)))
        else $error("record length above cap");

    a_file_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.last_byte) |=>
            (r_byte_pos == '0 && !r_pending_valid && r_fill == '0 && !r_waiting))
        else $error("state not cleared after last byte");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= MAX_QUERY)
        else $error("window fill out of range");
`endif

endmodule

// File: sim/fixed_string_line_matcher_unit_tb.sv
// testbench for fixed_string_line_matcher_unit: byte streams checked against a predictor
`timescale 1ns / 1ps
module fixed_string_line_matcher_unit_tb;
    import fslm_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int PHASE_ITEMS  = 270;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_stall;
    t_out_item             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [CFG_BITS-1:0]   pwdata;
    logic [CFG_BITS-1:0]   prdata;
    logic                  pready;

    // predictor state
    logic [7:0]            win_bytes [MAX_QUERY];
    int                    win_count;
    t_offset               next_offset;
    t_offset               seg_begin;
    t_offset               resume_at;
    t_offset               held_start;
    bit                    await_lf;
    bit                    held_valid;
    logic [QLEN_BITS-1:0]  cfg_len;
    logic [63:0]           cfg_low;
    logic [63:0]           cfg_high;

    t_out_item             expected_records [$];
    t_out_item             want_rec;
    int                    error_count = 0;
    int                    cycle_count = 0;
    int                    src_idle_pct = 0;
    int                    sink_idle_pct = 0;

    fixed_string_line_matcher_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_eol(logic [7:0] b);
        return (b == CH_LF) || (b == CH_CR);
    endfunction

    function automatic logic [7:0] query_at(int i);
        if (i < 8) return cfg_low[8*i +: 8];
        if (i < 16) return cfg_high[8*(i-8) +: 8];
        return 8'h00;
    endfunction

    function automatic void clear_match_state();
        int k;
        for (k = 0; k < MAX_QUERY; k++) win_bytes[k] = 8'h00;
        win_count   = 0;
        next_offset = '0;
        seg_begin   = '0;
        resume_at   = '0;
        await_lf    = 1'b0;
        held_valid  = 1'b0;
        held_start  = '0;
    endfunction

    function automatic void queue_record(logic [FILE_BITS-1:0] file, t_offset start,
                                         t_offset stop);
        t_offset   span;
        t_out_item rec;
        span            = stop - start;
        rec.match_file  = file;
        rec.line_offset = start;
        rec.line_length = (span > t_offset'(LINE_CAP)) ? LEN_BITS'(LINE_CAP) : LEN_BITS'(span);
        expected_records.push_back(rec);
    endfunction

    function automatic void predict_grep(t_in_item item);
        t_offset pos;
        t_offset hit_start;
        t_offset stop;
        t_offset m;
        bit      produced;
        bit      hit;
        bit      end_found;
        int      q;
        int      k;
        pos      = next_offset;
        produced = 1'b0;
        q        = int'(cfg_len);
        stop     = '0;
        // a break leaving the window moves the segment start
        if (win_count >= MAX_QUERY && is_eol(win_bytes[MAX_QUERY-1]))
            seg_begin = pos - t_offset'(MAX_QUERY - 1);
        for (k = MAX_QUERY - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
        win_bytes[0] = item.data_byte;
        if (win_count < MAX_QUERY) win_count++;

        if (held_valid && is_eol(item.data_byte)) begin
            queue_record(item.file_id, held_start, pos);
            held_valid = 1'b0;
            produced   = 1'b1;
        end
        if (await_lf && item.data_byte == CH_LF) begin
            await_lf  = 1'b0;
            resume_at = pos + 1;
        end

        if (q > MAX_QUERY) q = MAX_QUERY;
        if (q != 0 && !produced && !await_lf && win_count >= q) begin
            hit = 1'b1;
            m   = pos - t_offset'(q - 1);
            for (k = 0; k < q; k++) begin
                if (win_bytes[k] != query_at(q - 1 - k)) hit = 1'b0;
            end
            if (hit && m >= resume_at) begin
                hit_start = seg_begin;
                end_found = 1'b0;
                for (k = q; k < win_count; k++) begin
                    if (is_eol(win_bytes[k])) begin
                        hit_start = pos - t_offset'(k) + 1;
                        break;
                    end
                end
                for (k = q; k > 0; k--) begin
                    if (is_eol(win_bytes[k-1])) begin
                        stop      = pos - t_offset'(k - 1);
                        end_found = 1'b1;
                        break;
                    end
                end
                if (end_found) begin
                    queue_record(item.file_id, hit_start, stop);
                    produced = 1'b1;
                end else begin
                    held_valid = 1'b1;
                    held_start = hit_start;
                end
                // an LF inside the hit already reopens the search
                await_lf = 1'b1;
                for (k = q - 1; k > 0; k--) begin
                    if (win_bytes[k-1] == CH_LF) begin
                        resume_at = pos - t_offset'(k - 1) + 1;
                        await_lf  = 1'b0;
                        break;
                    end
                end
            end
        end

        next_offset = pos + 1;
        if (item.last_byte) begin
            if (held_valid && !produced) queue_record(item.file_id, held_start, pos + 1);
            clear_match_state();
        end
    endfunction

    task automatic send_byte(logic [7:0] b, logic [FILE_BITS-1:0] file, logic last);
        t_in_item item;
        item.data_byte = b;
        item.file_id   = file;
        item.last_byte = last;
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_grep(item);
    endtask

    task automatic send_text(string s, logic [FILE_BITS-1:0] file, bit ends_file);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i], file, ends_file && (i == s.len() - 1));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [REG_SEL_BITS-1:0] sel, logic [CFG_BITS-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_BITS'(sel) << REG_SEL_LSB;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_QUERY_LENGTH: cfg_len = value[QLEN_BITS-1:0];
            REG_QUERY_LOW:    cfg_low = value;
            REG_QUERY_HIGH:   cfg_high = value;
            default: ;
        endcase
    endtask

    task automatic write_query(logic [CFG_BITS-1:0] len, logic [63:0] lo, logic [63:0] hi);
        write_reg(REG_QUERY_LENGTH, len);
        write_reg(REG_QUERY_LOW, lo);
        write_reg(REG_QUERY_HIGH, hi);
    endtask

    function automatic logic [7:0] pick_query_char();
        case ($urandom_range(9))
            0: return CH_CR;
            1: return CH_LF;
            2: return 8'($urandom);
            default: return 8'h61 + 8'($urandom_range(3));
        endcase
    endfunction

    task automatic random_config();
        logic [63:0]         lo;
        logic [63:0]         hi;
        logic [CFG_BITS-1:0] len;
        int                  i;
        for (i = 0; i < 8; i++) begin
            lo[8*i +: 8] = pick_query_char();
            hi[8*i +: 8] = pick_query_char();
        end
        case ($urandom_range(11))
            0: len = CFG_BITS'(0);
            1: len = CFG_BITS'($urandom_range(17, 31));
            2, 3, 4: len = CFG_BITS'($urandom_range(6, 16));
            default: len = CFG_BITS'($urandom_range(1, 5));
        endcase
        write_query(len, lo, hi);
    endtask

    // lines built from query copies, partial copies, filler and breaks
    task automatic send_random_file(int size);
        logic [7:0]           text [$];
        logic [FILE_BITS-1:0] file;
        int                   q;
        int                   sel;
        int                   n;
        int                   i;
        q = (cfg_len > MAX_QUERY) ? MAX_QUERY : int'(cfg_len);
        while (text.size() < size) begin
            sel = $urandom_range(99);
            if (sel < 30) begin
                for (i = 0; i < q; i++) text.push_back(query_at(i));
            end else if (sel < 40) begin
                n = (q > 0) ? $urandom_range(q - 1) : 0;
                for (i = 0; i < n; i++) text.push_back(query_at(i));
            end else if (sel < 65) begin
                text.push_back(($urandom_range(4) == 0) ? 8'h20 : 8'h61 + 8'($urandom_range(3)));
            end else if (sel < 75) begin
                text.push_back(CH_LF);
            end else if (sel < 82) begin
                text.push_back(CH_CR);
            end else if (sel < 87) begin
                text.push_back(CH_CR);
                text.push_back(CH_LF);
            end else begin
                text.push_back(8'($urandom));
            end
        end
        file = FILE_BITS'($urandom);
        for (i = 0; i < text.size(); i++) begin
            if ($urandom_range(19) == 0) file = FILE_BITS'($urandom);
            send_byte(text[i], file, i == text.size() - 1);
        end
    endtask

    task automatic test_default_query();
        // after reset the query is one zero byte
        send_byte(8'h41, '0, 1'b0);
        send_byte(8'h00, '0, 1'b1);
    endtask

    task automatic test_segment_bounds();
        settle();
        write_query(CFG_BITS'(2), 64'h6261, 64'h0);
        // CR ends a segment, a second hit in one line is skipped, file number changes midway
        send_text("cab\r\nab ab\n", 14'h3FFF, 1'b0);
        send_text("ab", 14'h0000, 1'b1);
    endtask

    task automatic test_query_length_limits();
        int i;
        settle();
        write_query(CFG_BITS'(0), 64'h6261, 64'h0);
        send_text("ab", 14'h0001, 1'b1);
        settle();
        write_query('1, '1, '1);
        for (i = 0; i < MAX_QUERY; i++) send_byte(8'hFF, 14'h2AAA, i == MAX_QUERY - 1);
    endtask

    task automatic run_random_phase(int src_pct, int sink_pct);
        int sent;
        int size;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        settle();
        random_config();
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            if ($urandom_range(3) == 0) begin
                settle();
                random_config();
            end
            size = $urandom_range(8, 60);
            send_random_file(size);
            sent += size;
        end
    endtask

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < sink_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_records.size() == 0) begin
                $error("unexpected record: file %0d offset %0d length %0d",
                       out_data.match_file, out_data.line_offset, out_data.line_length);
                error_count++;
            end else begin
                want_rec = expected_records.pop_front();
                if (out_data.match_file !== want_rec.match_file) begin
                    $error("match_file: expected %0d, got %0d",
                           want_rec.match_file, out_data.match_file);
                    error_count++;
                end
                if (out_data.line_offset !== want_rec.line_offset) begin
                    $error("line_offset: expected %0d, got %0d",
                           want_rec.line_offset, out_data.line_offset);
                    error_count++;
                end
                if (out_data.line_length !== want_rec.line_length) begin
                    $error("line_length: expected %0d, got %0d",
                           want_rec.line_length, out_data.line_length);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_stall <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        cfg_len   = QLEN_BITS'(1);
        cfg_low   = '0;
        cfg_high  = '0;
        clear_match_state();
        src_idle_pct  = 37;
        sink_idle_pct = 70;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_default_query();
        test_segment_bounds();
        test_query_length_limits();
        run_random_phase(37, 70);
        run_random_phase(70, 37);
        run_random_phase(0, 0);
        settle();

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
